/* src/dmxm_pkg.sv */
`default_nettype none
package dmxm_pkg;

   // Default sizes, overridable at the top level
   localparam int UNIVERSE_BYTES_DEF = 512;
   localparam int MAX_LIGHTS_DEF     = 512;

   // Fixed field widths
   localparam int KIND_W   = 3;
   localparam int SIZE_W   = 10;
   localparam int INDEX_W  = 9;
   localparam int LEVEL_W  = 16;
   localparam int START_W  = 9;
   localparam int HDR_LEN  = 5;

   // Input kinds
   localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SET8  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SET16 = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RGB   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SEND  = 3'd4;

   // Frame bytes
   localparam logic [7:0] FRAME_SOM   = 8'h7E;
   localparam logic [7:0] FRAME_LABEL = 8'h06;
   localparam logic [7:0] FRAME_PAD   = 8'h00;
   localparam logic [7:0] FRAME_EOM   = 8'hE7;
   localparam logic [7:0] RGB_FILL    = 8'hFF;

   // Register file
   localparam int          CSR_ADDR_W        = 3;
   localparam int          CSR_DATA_W        = 32;
   localparam logic        CSR_CHAIN_ENABLED = 1'b0;

   // Command queue depth (power of two)
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SET,
      OP_SEND,
      OP_FAIL
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [SIZE_W-1:0]  size;
      logic [INDEX_W-1:0] idx;
      logic [2:0]         want;
      logic [3:0][7:0]    bytes;
   } cmd_type;

   typedef struct packed {
      logic               status;
      logic [INDEX_W-1:0] new_light;
      logic               tx_valid;
      logic [7:0]         tx_byte;
      logic               frame_last;
   } rsp_type;

endpackage
`default_nettype wire

/* src/dmxm_ram.sv */
`default_nettype none
module dmxm_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 512,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* src/dmxm_front.sv */
`default_nettype none
module dmxm_front (
   input  wire logic                         chain_enabled,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [dmxm_pkg::KIND_W-1:0]  req_kind,
   input  wire logic [dmxm_pkg::SIZE_W-1:0]  req_light_size,
   input  wire logic [dmxm_pkg::INDEX_W-1:0] req_light_index,
   input  wire logic [dmxm_pkg::LEVEL_W-1:0] req_level,
   input  wire logic [7:0]                   req_red,
   input  wire logic [7:0]                   req_green,
   input  wire logic [7:0]                   req_blue,
   input  wire logic                         queue_full,
   input  wire logic                         clearing,
   output logic                              push,
   output dmxm_pkg::cmd_type                 push_cmd
);

   // Stall while the queue is full or the universe store is being cleared
   assign req_ready = !queue_full && !clearing;
   assign push      = req_valid && req_ready;

   always_comb begin
      push_cmd       = '0;
      push_cmd.op    = dmxm_pkg::OP_FAIL;
      push_cmd.size  = req_light_size;
      push_cmd.idx   = req_light_index;
      if (chain_enabled) begin
         unique case (req_kind)
            dmxm_pkg::KIND_ADD: begin
               push_cmd.op = dmxm_pkg::OP_ADD;
            end
            dmxm_pkg::KIND_SET8: begin
               push_cmd.op       = dmxm_pkg::OP_SET;
               push_cmd.want     = 3'd1;
               push_cmd.bytes[0] = req_level[7:0];
            end
            dmxm_pkg::KIND_SET16: begin
               push_cmd.op       = dmxm_pkg::OP_SET;
               push_cmd.want     = 3'd2;
               push_cmd.bytes[0] = req_level[15:8];
               push_cmd.bytes[1] = req_level[7:0];
            end
            dmxm_pkg::KIND_RGB: begin
               push_cmd.op       = dmxm_pkg::OP_SET;
               push_cmd.want     = 3'd4;
               push_cmd.bytes[0] = req_red;
               push_cmd.bytes[1] = req_green;
               push_cmd.bytes[2] = req_blue;
               push_cmd.bytes[3] = dmxm_pkg::RGB_FILL;
            end
            dmxm_pkg::KIND_SEND: begin
               push_cmd.op = dmxm_pkg::OP_SEND;
            end
            default: begin
               push_cmd.op = dmxm_pkg::OP_FAIL;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

/* src/dmxm_queue.sv */
`default_nettype none
module dmxm_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire dmxm_pkg::cmd_type push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output dmxm_pkg::cmd_type      head,
   output logic                   empty
);

   localparam int QA = (dmxm_pkg::QUEUE_DEPTH > 1) ? $clog2(dmxm_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(dmxm_pkg::QUEUE_DEPTH + 1);

   dmxm_pkg::cmd_type entries_ff [dmxm_pkg::QUEUE_DEPTH];
   logic [QA-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QA-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full  = count_ff == CW'(dmxm_pkg::QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QA'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QA'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

/* src/dmxm_back.sv */
`default_nettype none
module dmxm_back #(
   parameter int UNIVERSE_BYTES = dmxm_pkg::UNIVERSE_BYTES_DEF,
   parameter int MAX_LIGHTS     = dmxm_pkg::MAX_LIGHTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              queue_empty,
   input  wire dmxm_pkg::cmd_type head,
   output logic                   pop,
   output logic                   clearing,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output dmxm_pkg::rsp_type      rsp
);

   localparam int UA        = (UNIVERSE_BYTES > 1) ? $clog2(UNIVERSE_BYTES) : 1;
   localparam int LA        = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
   localparam int LCW       = $clog2(MAX_LIGHTS + 1);
   localparam int OW        = $clog2(UNIVERSE_BYTES + 1);
   localparam int FRAME_LEN = dmxm_pkg::HDR_LEN + UNIVERSE_BYTES + 1;
   localparam int FW        = $clog2(FRAME_LEN + 1);
   localparam int LT_W      = dmxm_pkg::SIZE_W + dmxm_pkg::START_W;
   localparam logic [7:0] LEN_LO = 8'(UNIVERSE_BYTES % 256);
   localparam logic [7:0] LEN_HI = 8'((UNIVERSE_BYTES / 256) % 256);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_LOOKUP = 6'b000100,
      ST_WRITE  = 6'b001000,
      ST_FETCH  = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   state_type                      state_ff, state_in;
   dmxm_pkg::cmd_type              cur_ff, cur_in;
   dmxm_pkg::rsp_type              res_ff, res_in;
   dmxm_pkg::rsp_type              rsp_ff, rsp_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [LCW-1:0]                 light_count_ff, light_count_in;
   logic [OW-1:0]                  next_offset_ff, next_offset_in;
   logic [FW-1:0]                  fpos_ff, fpos_in;
   logic [UA-1:0]                  clr_ff, clr_in;
   logic [dmxm_pkg::START_W-1:0]   start_ff, start_in;
   logic [1:0]                     k_ff, k_in;

   logic                           lt_wr_en, lt_rd_en;
   logic [LT_W-1:0]                lt_wr_data, lt_rd_data;
   logic [dmxm_pkg::SIZE_W-1:0]    lt_bytes;
   logic [dmxm_pkg::START_W-1:0]   lt_start;
   logic                           uv_wr_en, uv_rd_en;
   logic [UA-1:0]                  uv_wr_addr, uv_rd_addr;
   logic [7:0]                     uv_wr_data, uv_rd_data;

   logic [dmxm_pkg::SIZE_W:0]      add_sum;
   logic [dmxm_pkg::SIZE_W-1:0]    wr_sum;
   logic [dmxm_pkg::SIZE_W:0]      end_sum;
   logic [FW-1:0]                  pos;
   logic [FW-1:0]                  data_ofs;
   logic                           pos_data;
   logic                           out_free;

   assign clearing  = state_ff == ST_CLEAR;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop       = (state_ff == ST_IDLE) && !queue_empty;

   assign {lt_bytes, lt_start} = lt_rd_data;

   assign add_sum  = (dmxm_pkg::SIZE_W + 1)'(next_offset_ff) + (dmxm_pkg::SIZE_W + 1)'(head.size);
   assign wr_sum   = dmxm_pkg::SIZE_W'(start_ff) + dmxm_pkg::SIZE_W'(k_ff);
   assign end_sum  = (dmxm_pkg::SIZE_W + 1)'(lt_start) + (dmxm_pkg::SIZE_W + 1)'(cur_ff.want);
   assign pos      = (fpos_ff >= FW'(FRAME_LEN)) ? '0 : fpos_ff;
   assign data_ofs = pos - FW'(dmxm_pkg::HDR_LEN);
   assign pos_data = (pos >= FW'(dmxm_pkg::HDR_LEN)) &&
                     (pos < FW'(dmxm_pkg::HDR_LEN + UNIVERSE_BYTES));

   assign lt_wr_data = {head.size, dmxm_pkg::START_W'(next_offset_ff)};

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff;
      light_count_in = light_count_ff;
      next_offset_in = next_offset_ff;
      fpos_in        = fpos_ff;
      clr_in         = clr_ff;
      start_in       = start_ff;
      k_in           = k_ff;
      lt_wr_en       = 1'b0;
      lt_rd_en       = 1'b0;
      uv_wr_en       = 1'b0;
      uv_wr_addr     = clr_ff;
      uv_wr_data     = dmxm_pkg::FRAME_PAD;
      uv_rd_en       = 1'b0;
      uv_rd_addr     = data_ofs[UA-1:0];

      // Drop the output beat once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            uv_wr_en = 1'b1;
            clr_in   = clr_ff + UA'(1);
            if (clr_ff == UA'(UNIVERSE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!queue_empty) begin
               cur_in        = head;
               res_in        = '0;
               res_in.status = 1'b1;
               state_in      = ST_EMIT;
               case (head.op)
                  dmxm_pkg::OP_ADD: begin
                     if ((light_count_ff < LCW'(MAX_LIGHTS)) &&
                         (add_sum <= (dmxm_pkg::SIZE_W + 1)'(UNIVERSE_BYTES))) begin
                        lt_wr_en         = 1'b1;
                        res_in.status    = 1'b0;
                        res_in.new_light = dmxm_pkg::INDEX_W'(light_count_ff);
                        light_count_in   = light_count_ff + LCW'(1);
                        next_offset_in   = add_sum[OW-1:0];
                     end
                  end
                  dmxm_pkg::OP_SET: begin
                     if (dmxm_pkg::SIZE_W'(head.idx) < dmxm_pkg::SIZE_W'(light_count_ff)) begin
                        lt_rd_en = 1'b1;
                        state_in = ST_LOOKUP;
                     end
                  end
                  dmxm_pkg::OP_SEND: begin
                     res_in.status   = 1'b0;
                     res_in.tx_valid = 1'b1;
                     if (pos == FW'(FRAME_LEN - 1)) begin
                        res_in.frame_last = 1'b1;
                        fpos_in           = '0;
                     end else begin
                        fpos_in = pos + FW'(1);
                     end
                     if (pos_data) begin
                        uv_rd_en = 1'b1;
                        state_in = ST_FETCH;
                     end else if (pos == FW'(0)) begin
                        res_in.tx_byte = dmxm_pkg::FRAME_SOM;
                     end else if (pos == FW'(1)) begin
                        res_in.tx_byte = dmxm_pkg::FRAME_LABEL;
                     end else if (pos == FW'(2)) begin
                        res_in.tx_byte = LEN_LO;
                     end else if (pos == FW'(3)) begin
                        res_in.tx_byte = LEN_HI;
                     end else if (pos == FW'(4)) begin
                        res_in.tx_byte = dmxm_pkg::FRAME_PAD;
                     end else begin
                        res_in.tx_byte = dmxm_pkg::FRAME_EOM;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            if ((lt_bytes == dmxm_pkg::SIZE_W'(cur_ff.want)) &&
                (end_sum <= (dmxm_pkg::SIZE_W + 1)'(UNIVERSE_BYTES))) begin
               start_in = lt_start;
               k_in     = '0;
               state_in = ST_WRITE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_WRITE: begin
            uv_wr_en   = 1'b1;
            uv_wr_addr = wr_sum[UA-1:0];
            uv_wr_data = cur_ff.bytes[k_ff];
            k_in       = k_ff + 2'd1;
            if (k_ff == 2'(cur_ff.want - 3'd1)) begin
               res_in.status = 1'b0;
               state_in      = ST_EMIT;
            end
         end
         ST_FETCH: begin
            res_in.tx_byte = uv_rd_data;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         rsp_valid_ff   <= 1'b0;
         light_count_ff <= '0;
         next_offset_ff <= '0;
         fpos_ff        <= '0;
         clr_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         light_count_ff <= light_count_in;
         next_offset_ff <= next_offset_in;
         fpos_ff        <= fpos_in;
         clr_ff         <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
      start_ff <= start_in;
      k_ff     <= k_in;
   end

   dmxm_ram #(
      .WIDTH (LT_W),
      .DEPTH (MAX_LIGHTS)
   ) u_light_ram (
      .clock   (clock),
      .wr_en   (lt_wr_en),
      .wr_addr (light_count_ff[LA-1:0]),
      .wr_data (lt_wr_data),
      .rd_en   (lt_rd_en),
      .rd_addr (head.idx[LA-1:0]),
      .rd_data (lt_rd_data)
   );

   dmxm_ram #(
      .WIDTH (8),
      .DEPTH (UNIVERSE_BYTES)
   ) u_universe_ram (
      .clock   (clock),
      .wr_en   (uv_wr_en),
      .wr_addr (uv_wr_addr),
      .wr_data (uv_wr_data),
      .rd_en   (uv_rd_en),
      .rd_addr (uv_rd_addr),
      .rd_data (uv_rd_data)
   );

endmodule
`default_nettype wire

/* src/dmx_universe_channel_mapper.sv */
// DMX universe channel mapper: light table, universe store and framed byte stream.
// Request channel (req_*): one command beat per item - add light, set byte level,
// set 16-bit level, set RGB, or send the next frame byte. Response channel (rsp_*):
// exactly one beat per request, in order, with status, the new light index, and the
// frame byte for sends (frame_last marks the closing E7 byte).
// Register port: chain_enabled at byte address 0; while it is clear every command
// answers with status 1 and leaves all state untouched.
// A request passes through the command queue to the back end, which goes from idle
// straight to the emit state for adds, header or trailer bytes and commands refused
// at once (chain off, unknown kind, light not in the table); data bytes add one
// universe store read, sets add a light table lookup and, when the light matches,
// one store write per byte. The back end handles one command at a time and takes
// the next only once the last is answered; the universe store has a single write port.
// Reset: light table empty, frame restarts at the header, register cleared. The
// universe store is then zeroed one byte a cycle, all UNIVERSE_BYTES bytes, with
// req_ready held low while it clears.
// A stalled receiver holds the response beat; one further command completes and
// waits in the back end, and two more queue behind it before req_ready drops.
`default_nettype none
module dmx_universe_channel_mapper #(
   parameter int UNIVERSE_BYTES = dmxm_pkg::UNIVERSE_BYTES_DEF,
   parameter int MAX_LIGHTS     = dmxm_pkg::MAX_LIGHTS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [dmxm_pkg::KIND_W-1:0]      req_kind,
   input  wire logic [dmxm_pkg::SIZE_W-1:0]      req_light_size,
   input  wire logic [dmxm_pkg::INDEX_W-1:0]     req_light_index,
   input  wire logic [dmxm_pkg::LEVEL_W-1:0]     req_level,
   input  wire logic [7:0]                       req_red,
   input  wire logic [7:0]                       req_green,
   input  wire logic [7:0]                       req_blue,
   // response channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_status,
   output logic [dmxm_pkg::INDEX_W-1:0]          rsp_new_light,
   output logic                                  rsp_tx_valid,
   output logic [7:0]                            rsp_tx_byte,
   output logic                                  rsp_frame_last,
   // register port
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [dmxm_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [dmxm_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [dmxm_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                  pready
);

   logic              chain_enabled_ff, chain_enabled_in;
   logic              csr_index;
   logic              push, pop;
   logic              queue_full, queue_empty, clearing;
   dmxm_pkg::cmd_type push_cmd, head;
   dmxm_pkg::rsp_type rsp;

   // Register port: one register, word index taken from paddr bit 2
   assign pready    = 1'b1;
   assign csr_index = paddr[2];

   always_comb begin
      chain_enabled_in = chain_enabled_ff;
      if (psel && penable && pwrite && pready &&
          (csr_index == dmxm_pkg::CSR_CHAIN_ENABLED)) begin
         chain_enabled_in = pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_index == dmxm_pkg::CSR_CHAIN_ENABLED) begin
         prdata[0] = chain_enabled_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_enabled_ff <= 1'b0;
      end else begin
         chain_enabled_ff <= chain_enabled_in;
      end
   end

   // Front end: accept and classify commands
   dmxm_front u_front (
      .chain_enabled   (chain_enabled_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_light_size  (req_light_size),
      .req_light_index (req_light_index),
      .req_level       (req_level),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .queue_full      (queue_full),
      .clearing        (clearing),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   // Short command queue decoupling the two halves
   dmxm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .head     (head),
      .empty    (queue_empty)
   );

   // Back end: light table, universe store, frame sequencing, response register
   dmxm_back #(
      .UNIVERSE_BYTES (UNIVERSE_BYTES),
      .MAX_LIGHTS     (MAX_LIGHTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .clearing    (clearing),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp)
   );

   assign rsp_status     = rsp.status;
   assign rsp_new_light  = rsp.new_light;
   assign rsp_tx_valid   = rsp.tx_valid;
   assign rsp_tx_byte    = rsp.tx_byte;
   assign rsp_frame_last = rsp.frame_last;

endmodule
`default_nettype wire

/* src/dmxm_checker.sv */
`default_nettype none
module dmxm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_status,
   input wire logic [8:0] rsp_new_light,
   input wire logic       rsp_tx_valid,
   input wire logic [7:0] rsp_tx_byte,
   input wire logic       rsp_frame_last
);

   // Hold the response beat while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_new_light) && $stable(rsp_tx_valid) &&
         $stable(rsp_tx_byte) && $stable(rsp_frame_last))
      else $error("response beat changed while stalled");

   a_tx_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_valid |-> !rsp_status)
      else $error("frame byte with error status");

   a_last_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_last |-> rsp_tx_valid && (rsp_tx_byte == 8'hE7))
      else $error("frame end without closing byte");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |->
         (rsp_new_light == 9'd0) && !rsp_tx_valid && (rsp_tx_byte == 8'd0))
      else $error("error beat carries payload");

   // Store clearing follows reset, so no request is taken straight after it
   a_clear_stall: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during store clearing");

endmodule

bind dmx_universe_channel_mapper dmxm_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_new_light  (rsp_new_light),
   .rsp_tx_valid   (rsp_tx_valid),
   .rsp_tx_byte    (rsp_tx_byte),
   .rsp_frame_last (rsp_frame_last)
);
`default_nettype wire

/* bench/dmx_universe_channel_mapper_test.sv */
`default_nettype none
module dmx_universe_channel_mapper_test;

   localparam int UNIV          = dmxm_pkg::UNIVERSE_BYTES_DEF;
   localparam int LIGHTS        = dmxm_pkg::MAX_LIGHTS_DEF;
   localparam int FRAME_LEN     = dmxm_pkg::HDR_LEN + UNIV + 1;
   // kinds the block does not know; they must answer with an error
   localparam logic [dmxm_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd5;
   localparam logic [dmxm_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;
   localparam logic [dmxm_pkg::CSR_ADDR_W-1:0] CHAIN_ADDR =
      dmxm_pkg::CSR_ADDR_W'(4 * int'(dmxm_pkg::CSR_CHAIN_ENABLED));
   // next word up: no register lives there, writes must be dropped
   localparam logic [dmxm_pkg::CSR_ADDR_W-1:0] SPARE_ADDR =
      dmxm_pkg::CSR_ADDR_W'(4 * (int'(dmxm_pkg::CSR_CHAIN_ENABLED) + 1));
   localparam logic [dmxm_pkg::CSR_DATA_W-1:0] CHAIN_OFF = '0;
   localparam logic [dmxm_pkg::CSR_DATA_W-1:0] CHAIN_ON  = dmxm_pkg::CSR_DATA_W'(1);
   localparam int PHASE_ITEMS    = 55;
   localparam int DISABLED_ITEMS = 12;
   localparam int TAIL_CYCLES    = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   // shares of the random mix, in percent
   localparam int NOISE_PCT      = 8;
   localparam int SEND_PCT       = 35;
   localparam int ADD_PCT        = 45;

   typedef struct packed {
      logic [dmxm_pkg::KIND_W-1:0]  kind;
      logic [dmxm_pkg::SIZE_W-1:0]  size;
      logic [dmxm_pkg::INDEX_W-1:0] index;
      logic [dmxm_pkg::LEVEL_W-1:0] level;
      logic [7:0]                   red;
      logic [7:0]                   green;
      logic [7:0]                   blue;
   } light_cmd_type;

   // Mirror of the light table, universe store and frame pointer. Every
   // accepted command beat queues the response beat it must produce.
   class universe_tracker;
      logic [7:0]        universe [UNIV];
      int                light_start [LIGHTS];
      int                light_bytes [LIGHTS];
      int                light_count;
      int                next_offset;
      int                frame_pos;
      bit                chain_on;
      int                errors;
      dmxm_pkg::rsp_type owed [$];

      function new();
         foreach (universe[i]) universe[i] = 8'h00;
         light_count = 0;
         next_offset = 0;
         frame_pos   = 0;
         chain_on    = 1'b0;
         errors      = 0;
      endfunction

      function void write_register(logic [dmxm_pkg::CSR_ADDR_W-1:0] addr,
                                   logic [dmxm_pkg::CSR_DATA_W-1:0] value);
         if (int'(addr >> 2) == int'(dmxm_pkg::CSR_CHAIN_ENABLED)) chain_on = value[0];
      endfunction

      function void store(int addr, logic [7:0] value);
         if (addr < UNIV) universe[addr] = value;
      endfunction

      function logic [7:0] frame_byte(int pos);
         if (pos == 0) return dmxm_pkg::FRAME_SOM;
         if (pos == 1) return dmxm_pkg::FRAME_LABEL;
         if (pos == 2) return 8'(UNIV);
         if (pos == 3) return 8'(UNIV >> 8);
         if (pos == 4) return dmxm_pkg::FRAME_PAD;
         if (pos < dmxm_pkg::HDR_LEN + UNIV) return universe[pos - dmxm_pkg::HDR_LEN];
         return dmxm_pkg::FRAME_EOM;
      endfunction

      function bit light_fits(int idx, int want, output int start);
         start = 0;
         if (idx >= light_count) return 1'b0;
         if (light_bytes[idx] != want) return 1'b0;
         start = light_start[idx];
         return start + want <= UNIV;
      endfunction

      function void note_command(light_cmd_type c);
         dmxm_pkg::rsp_type e;
         int                start;
         e        = '0;
         e.status = 1'b1;
         start    = 0;
         if (chain_on) begin
            case (c.kind)
               dmxm_pkg::KIND_ADD: begin
                  if (light_count < LIGHTS && next_offset + int'(c.size) <= UNIV) begin
                     light_start[light_count] = next_offset % 512;
                     light_bytes[light_count] = int'(c.size);
                     e.new_light = dmxm_pkg::INDEX_W'(light_count);
                     light_count++;
                     next_offset += int'(c.size);
                     e.status = 1'b0;
                  end
               end
               dmxm_pkg::KIND_SET8: begin
                  if (light_fits(int'(c.index), 1, start)) begin
                     store(start, c.level[7:0]);
                     e.status = 1'b0;
                  end
               end
               dmxm_pkg::KIND_SET16: begin
                  // big-endian: high byte first
                  if (light_fits(int'(c.index), 2, start)) begin
                     store(start, c.level[15:8]);
                     store(start + 1, c.level[7:0]);
                     e.status = 1'b0;
                  end
               end
               dmxm_pkg::KIND_RGB: begin
                  if (light_fits(int'(c.index), 4, start)) begin
                     store(start, c.red);
                     store(start + 1, c.green);
                     store(start + 2, c.blue);
                     store(start + 3, dmxm_pkg::RGB_FILL);
                     e.status = 1'b0;
                  end
               end
               dmxm_pkg::KIND_SEND: begin
                  if (frame_pos >= FRAME_LEN) frame_pos = 0;
                  e.tx_byte  = frame_byte(frame_pos);
                  e.tx_valid = 1'b1;
                  e.status   = 1'b0;
                  if (frame_pos == FRAME_LEN - 1) begin
                     e.frame_last = 1'b1;
                     frame_pos    = 0;
                  end else begin
                     frame_pos++;
                  end
               end
               default: ;
            endcase
         end
         owed.push_back(e);
      endfunction

      function void mismatch(string field, logic [15:0] want, logic [15:0] got);
         errors++;
         if (errors <= 10)
            $display("%m: %s mismatch, expected %0h got %0h", field, want, got);
      endfunction

      function void check_answer(dmxm_pkg::rsp_type got);
         dmxm_pkg::rsp_type want;
         if (owed.size() == 0) begin
            errors++;
            if (errors <= 10) $display("%m: response beat with nothing outstanding");
            return;
         end
         want = owed.pop_front();
         if (got.status !== want.status)
            mismatch("status", 16'(want.status), 16'(got.status));
         if (got.new_light !== want.new_light)
            mismatch("new_light", 16'(want.new_light), 16'(got.new_light));
         if (got.tx_valid !== want.tx_valid)
            mismatch("tx_valid", 16'(want.tx_valid), 16'(got.tx_valid));
         if (got.tx_byte !== want.tx_byte)
            mismatch("tx_byte", 16'(want.tx_byte), 16'(got.tx_byte));
         if (got.frame_last !== want.frame_last)
            mismatch("frame_last", 16'(want.frame_last), 16'(got.frame_last));
      endfunction

      function int pending();
         return owed.size();
      endfunction
   endclass

   logic                              clock           = 1'b0;
   logic                              reset           = 1'b1;
   logic                              req_valid       = 1'b0;
   logic                              req_ready;
   logic [dmxm_pkg::KIND_W-1:0]       req_kind        = '0;
   logic [dmxm_pkg::SIZE_W-1:0]       req_light_size  = '0;
   logic [dmxm_pkg::INDEX_W-1:0]      req_light_index = '0;
   logic [dmxm_pkg::LEVEL_W-1:0]      req_level       = '0;
   logic [7:0]                        req_red         = '0;
   logic [7:0]                        req_green       = '0;
   logic [7:0]                        req_blue        = '0;
   logic                              rsp_valid;
   logic                              rsp_ready       = 1'b0;
   logic                              rsp_status;
   logic [dmxm_pkg::INDEX_W-1:0]      rsp_new_light;
   logic                              rsp_tx_valid;
   logic [7:0]                        rsp_tx_byte;
   logic                              rsp_frame_last;
   logic                              psel            = 1'b0;
   logic                              penable         = 1'b0;
   logic                              pwrite          = 1'b0;
   logic [dmxm_pkg::CSR_ADDR_W-1:0]   paddr           = '0;
   logic [dmxm_pkg::CSR_DATA_W-1:0]   pwdata          = '0;
   logic [dmxm_pkg::CSR_DATA_W-1:0]   prdata;
   logic                              pready;

   universe_tracker   sb;
   dmxm_pkg::rsp_type seen;
   int                sender_idle_pct    = 0;
   int                receiver_stall_pct = 0;
   int                quiet_cycles       = 0;

   dmx_universe_channel_mapper dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_light_size  (req_light_size),
      .req_light_index (req_light_index),
      .req_level       (req_level),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_new_light   (rsp_new_light),
      .rsp_tx_valid    (rsp_tx_valid),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_frame_last  (rsp_frame_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: stall at random, at the rate the current phase sets.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // Compare every response beat taken by the receiver with the oldest
   // outstanding expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         seen.status     = rsp_status;
         seen.new_light  = rsp_new_light;
         seen.tx_valid   = rsp_tx_valid;
         seen.tx_byte    = rsp_tx_byte;
         seen.frame_last = rsp_frame_last;
         sb.check_answer(seen);
      end
   end

   // Watchdog: give up once no beat has moved on either channel for too long.
   // The limit covers the store clearing pass after reset as well.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic light_cmd_type make_cmd(logic [dmxm_pkg::KIND_W-1:0] kind,
                                              int size, int index, int level,
                                              int red, int green, int blue);
      light_cmd_type c;
      c.kind  = kind;
      c.size  = dmxm_pkg::SIZE_W'(size);
      c.index = dmxm_pkg::INDEX_W'(index);
      c.level = dmxm_pkg::LEVEL_W'(level);
      c.red   = 8'(red);
      c.green = 8'(green);
      c.blue  = 8'(blue);
      return c;
   endfunction

   // Draw the next random command. Most beats are well formed: sets address a
   // light that exists with the kind matching its size, adds fit the room left.
   // A small share is raw noise on every field.
   function automatic light_cmd_type next_command();
      light_cmd_type c;
      int            roll;
      int            room;
      int            pick;
      c.kind  = dmxm_pkg::KIND_ADD;
      c.size  = dmxm_pkg::SIZE_W'($urandom_range(0, 1023));
      c.index = dmxm_pkg::INDEX_W'($urandom_range(0, 511));
      c.level = dmxm_pkg::LEVEL_W'($urandom_range(0, 65535));
      c.red   = 8'($urandom_range(0, 255));
      c.green = 8'($urandom_range(0, 255));
      c.blue  = 8'($urandom_range(0, 255));
      roll    = $urandom_range(0, 99);
      if (roll < NOISE_PCT) begin
         c.kind = dmxm_pkg::KIND_W'($urandom_range(0, 7));
      end else if (roll < NOISE_PCT + SEND_PCT) begin
         c.kind = dmxm_pkg::KIND_SEND;
      end else if (roll < NOISE_PCT + SEND_PCT + ADD_PCT) begin
         room = UNIV - sb.next_offset;
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            c.size = '0;
         end else if (pick == 1) begin
            // fill the universe exactly, but only near the end of it
            c.size = dmxm_pkg::SIZE_W'((room <= 16) ? room : 1);
         end else if (pick == 2) begin
            c.size = dmxm_pkg::SIZE_W'(room + 1);
         end else if (room == 0) begin
            c.size = '0;
         end else if (pick == 3) begin
            c.size = dmxm_pkg::SIZE_W'($urandom_range(0, 8));
         end else begin
            c.size = dmxm_pkg::SIZE_W'(1 << $urandom_range(0, 2));
         end
      end else begin
         c.kind = dmxm_pkg::KIND_W'($urandom_range(dmxm_pkg::KIND_SET8, dmxm_pkg::KIND_RGB));
         if (sb.light_count > 0) begin
            c.index = dmxm_pkg::INDEX_W'($urandom_range(0, sb.light_count - 1));
            if ($urandom_range(0, 7) != 0) begin
               case (sb.light_bytes[c.index])
                  1:       c.kind = dmxm_pkg::KIND_SET8;
                  2:       c.kind = dmxm_pkg::KIND_SET16;
                  4:       c.kind = dmxm_pkg::KIND_RGB;
                  default: ;
               endcase
            end
         end
      end
      return c;
   endfunction

   // Present one command beat; hold it until the block takes it.
   task automatic send_item(input light_cmd_type c);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= c.kind;
      req_light_size  <= c.size;
      req_light_index <= c.index;
      req_level       <= c.level;
      req_red         <= c.red;
      req_green       <= c.green;
      req_blue        <= c.blue;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_command(c);
   endtask

   // Drop valid and hold off until every owed response beat has come back.
   task automatic wait_for_answers();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready.
   task automatic write_csr(input logic [dmxm_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [dmxm_pkg::CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.write_register(addr, value);
   endtask

   initial begin
      int phase;
      int count;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Chain disabled: a send, an add and a set must fail and the frame must not advance.
      write_csr(CHAIN_ADDR, CHAIN_OFF);
      send_item(make_cmd(dmxm_pkg::KIND_SEND, 0, 0, 0, 0, 0, 0));
      send_item(make_cmd(dmxm_pkg::KIND_ADD, 512, 0, 0, 0, 0, 0));
      send_item(make_cmd(dmxm_pkg::KIND_SET8, 1, 0, 16'h00FF, 0, 0, 0));
      wait_for_answers();
      // a write to an unused address must leave the chain disabled
      write_csr(SPARE_ADDR, CHAIN_ON);
      send_item(make_cmd(dmxm_pkg::KIND_SEND, 0, 0, 0, 0, 0, 0));
      wait_for_answers();
      write_csr(CHAIN_ADDR, CHAIN_ON);

      // Build a small table: sizes 1, 2, 4, an odd size and an empty light.
      send_item(make_cmd(dmxm_pkg::KIND_SEND, 0, 0, 0, 0, 0, 0));
      send_item(make_cmd(dmxm_pkg::KIND_ADD, 1, 0, 0, 0, 0, 0));
      send_item(make_cmd(dmxm_pkg::KIND_ADD, 2, 0, 0, 0, 0, 0));
      send_item(make_cmd(dmxm_pkg::KIND_ADD, 4, 0, 0, 0, 0, 0));
      send_item(make_cmd(dmxm_pkg::KIND_ADD, 3, 0, 0, 0, 0, 0));
      send_item(make_cmd(dmxm_pkg::KIND_ADD, 0, 0, 0, 0, 0, 0));
      // overflow: far past the end, then one byte past it
      send_item(make_cmd(dmxm_pkg::KIND_ADD, 1023, 511, 16'hFFFF, 255, 255, 255));
      send_item(make_cmd(dmxm_pkg::KIND_ADD, UNIV - 9, 0, 0, 0, 0, 0));
      // matching sets on the one-, two- and four-byte lights
      send_item(make_cmd(dmxm_pkg::KIND_SET8, 0, 0, 16'hFFFF, 0, 0, 0));
      send_item(make_cmd(dmxm_pkg::KIND_SET16, 0, 1, 16'hA55A, 0, 0, 0));
      send_item(make_cmd(dmxm_pkg::KIND_RGB, 0, 2, 0, 8'h12, 8'h34, 8'h56));
      // size mismatches and a light that does not exist
      send_item(make_cmd(dmxm_pkg::KIND_SET8, 0, 2, 16'h0077, 0, 0, 0));
      send_item(make_cmd(dmxm_pkg::KIND_SET16, 0, 3, 16'h1234, 0, 0, 0));
      send_item(make_cmd(dmxm_pkg::KIND_RGB, 0, 4, 0, 255, 255, 255));
      send_item(make_cmd(dmxm_pkg::KIND_SET8, 0, 511, 16'h00AA, 0, 0, 0));
      // unknown kinds with every other field at its maximum
      for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
         send_item(make_cmd(dmxm_pkg::KIND_W'(k), 1023, 511, 16'hFFFF, 255, 255, 255));
      // rest of the header, then the first universe byte
      repeat (5) send_item(make_cmd(dmxm_pkg::KIND_SEND, 0, 0, 0, 0, 0, 0));
      wait_for_answers();

      // One whole frame of sends: every universe byte, the closing byte, the
      // wrap back to the header and on to where the frame stood.
      repeat (FRAME_LEN) send_item(make_cmd(dmxm_pkg::KIND_SEND, 0, 0, 0, 0, 0, 0));
      wait_for_answers();

      // Random phases: no idling, idle sender, stalling receiver, both.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 71;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 71;
            end
            default: begin
               sender_idle_pct    = 15;
               receiver_stall_pct = 15;
            end
         endcase
         for (count = 0; count < PHASE_ITEMS; count++) begin
            send_item(next_command());
            // now and then let the pipeline run dry
            if ($urandom_range(0, 19) == 0) wait_for_answers();
         end
         wait_for_answers();
         // short disabled stretch between phases; the frame must hold its place
         if (phase < 3) begin
            write_csr(CHAIN_ADDR, CHAIN_OFF);
            repeat (DISABLED_ITEMS) send_item(next_command());
            wait_for_answers();
            write_csr(CHAIN_ADDR, CHAIN_ON);
         end
      end

      wait_for_answers();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire
